### rtl/jued_pkg.sv
`timescale 1ns / 1ps

package jued_pkg;

  // Escape progress: backslash held, 'u' seen, then one to three digits seen
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_BSL  = 6'b000010,
    PH_U    = 6'b000100,
    PH_D1   = 6'b001000,
    PH_D2   = 6'b010000,
    PH_D3   = 6'b100000
  } phase_t;

  // One output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       bad;
    logic       last;
  } res_t;

  localparam logic [7:0]  CH_BSL    = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  CONT      = 8'h80;
  localparam logic [15:0] LIM_ONE   = 16'h0080;
  localparam logic [15:0] LIM_TWO   = 16'h0800;

  // Map an ASCII hex digit to {valid, nibble}; nibble is zero when not hex
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Build a plain data transaction
  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r.data    = b;
    r.present = 1'b1;
    r.bad     = 1'b0;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

### rtl/json_unicode_escape_decoder_top.sv
`timescale 1ns / 1ps

// JSON \uXXXX escape decoder, one text byte per input transaction.
// Input channel: in_valid / in_stall carry in_byte and in_last (last byte of
// the text). Output channel: out_valid / out_stall carry out_byte,
// byte_present, bad_hex and out_last.
// Ordinary bytes come through one for one; a complete escape yields the
// UTF-8 encoding of its code, one to three bytes, out of its final digit.
// A result is registered and appears the cycle after its input transaction.
// One input byte per cycle while each byte gives at most one result and out_stall
// stays low. An input that gives more than one result holds the input side until
// the three-entry result holder, drained one entry per cycle while out_stall is
// low, is down to its last entry.
// A new input is taken in the same cycle that the last held result leaves.
// If the final byte gives no data, a single marker with byte_present low
// and out_last high closes the text.
// Reset (rst, synchronous) empties the result holder and returns to idle.
// While out_stall is high the head result holds steady and in_stall rises
// as soon as the holder is not about to empty.
module json_unicode_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       bad_hex,
  output logic       out_last
);

  jued_pkg::phase_t        phase, phase_next;
  logic [11:0]             accum, accum_next;
  logic                    dig_err, dig_err_next;
  jued_pkg::res_t [2:0]    hold;
  logic [1:0]              cnt;
  jued_pkg::res_t [2:0]    res;
  logic [1:0]              res_cnt;
  logic [4:0]              hex;
  logic [15:0]             code;
  logic                    in_acc;
  logic                    out_pop;

  // Handshake
  assign out_valid = (cnt != 2'd0);
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = !((cnt == 2'd0) || ((cnt == 2'd1) && !out_stall));
  assign in_acc    = in_valid && !in_stall;

  assign out_byte     = hold[0].data;
  assign byte_present = hold[0].present;
  assign bad_hex      = hold[0].bad;
  assign out_last     = hold[0].last;

  assign hex  = jued_pkg::hex_nib(in_byte);
  assign code = {accum, hex[3:0]};

  // Decode one byte into state updates and up to three results
  always_comb begin
    phase_next   = phase;
    accum_next   = accum;
    dig_err_next = dig_err;
    res          = '0;
    res_cnt      = 2'd0;
    unique case (phase) inside
      jued_pkg::PH_BSL: begin
        if (in_byte == jued_pkg::CH_U) begin
          phase_next   = jued_pkg::PH_U;
          accum_next   = 12'd0;
          dig_err_next = 1'b0;
        end else begin
          res[0]  = jued_pkg::mk_byte(jued_pkg::CH_BSL);
          res_cnt = 2'd1;
          if (in_byte != jued_pkg::CH_BSL) begin
            res[1]     = jued_pkg::mk_byte(in_byte);
            res_cnt    = 2'd2;
            phase_next = jued_pkg::PH_IDLE;
          end
        end
      end
      jued_pkg::PH_U, jued_pkg::PH_D1, jued_pkg::PH_D2: begin
        accum_next   = {accum[7:0], hex[3:0]};
        dig_err_next = dig_err || !hex[4];
        if (phase == jued_pkg::PH_U) begin
          phase_next = jued_pkg::PH_D1;
        end else if (phase == jued_pkg::PH_D1) begin
          phase_next = jued_pkg::PH_D2;
        end else begin
          phase_next = jued_pkg::PH_D3;
        end
      end
      jued_pkg::PH_D3: begin
        if (!hex[4] || dig_err) begin
          res[0]     = jued_pkg::mk_byte(8'd0);
          res[0].bad = 1'b1;
          res_cnt    = 2'd1;
        end else if (code < jued_pkg::LIM_ONE) begin
          res[0]  = jued_pkg::mk_byte(code[7:0]);
          res_cnt = 2'd1;
        end else if (code < jued_pkg::LIM_TWO) begin
          res[0]  = jued_pkg::mk_byte(jued_pkg::LEAD2 | {3'd0, code[10:6]});
          res[1]  = jued_pkg::mk_byte(jued_pkg::CONT | {2'd0, code[5:0]});
          res_cnt = 2'd2;
        end else begin
          res[0]  = jued_pkg::mk_byte(jued_pkg::LEAD3 | {4'd0, code[15:12]});
          res[1]  = jued_pkg::mk_byte(jued_pkg::CONT | {2'd0, code[11:6]});
          res[2]  = jued_pkg::mk_byte(jued_pkg::CONT | {2'd0, code[5:0]});
          res_cnt = 2'd3;
        end
        phase_next   = jued_pkg::PH_IDLE;
        accum_next   = 12'd0;
        dig_err_next = 1'b0;
      end
      default: begin
        phase_next = jued_pkg::PH_IDLE;
        if (in_byte == jued_pkg::CH_BSL) begin
          phase_next = jued_pkg::PH_BSL;
        end else begin
          res[0]  = jued_pkg::mk_byte(in_byte);
          res_cnt = 2'd1;
        end
      end
    endcase

    // Close the text: flush a held backslash, drop a cut-off escape
    if (in_last) begin
      if (phase_next == jued_pkg::PH_BSL) begin
        res[res_cnt] = jued_pkg::mk_byte(jued_pkg::CH_BSL);
        res_cnt      = res_cnt + 2'd1;
      end
      if (res_cnt == 2'd0) begin
        res[0].present = 1'b0;
        res_cnt        = 2'd1;
      end
      res[res_cnt - 2'd1].last = 1'b1;
      phase_next   = jued_pkg::PH_IDLE;
      accum_next   = 12'd0;
      dig_err_next = 1'b0;
    end
  end

  // Advance escape state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= jued_pkg::PH_IDLE;
      accum   <= 12'd0;
      dig_err <= 1'b0;
    end else if (in_acc) begin
      phase   <= phase_next;
      accum   <= accum_next;
      dig_err <= dig_err_next;
    end
  end

  // Load the result holder on accept, otherwise shift out one entry per pop
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_acc) begin
      cnt <= res_cnt;
    end else if (out_pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold <= res;
    end else if (out_pop) begin
      hold[0] <= hold[1];
      hold[1] <= hold[2];
    end
  end

  // A bad escape always shows as a present zero byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_hex |-> out_byte == 8'd0 && byte_present)
    else $error("bad_hex result carries data");

  // An end-only marker is the closing transaction of the text
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_present |-> out_last && out_byte == 8'd0 && !bad_hex)
    else $error("empty marker not final");

  // The final byte of a text leaves no escape pending
  assert property (@(posedge clk) disable iff (rst)
    in_acc && in_last |=> phase == jued_pkg::PH_IDLE && !dig_err)
    else $error("escape state not cleared after last byte");

  // Draining the only held result with no new input empties the output
  assert property (@(posedge clk) disable iff (rst)
    out_pop && cnt == 2'd1 && !in_acc |=> !out_valid)
    else $error("result repeated after drain");

endmodule

### bench/utf8_stream_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the escape decoder, predicts the UTF-8 output
// transactions for every accepted text byte and compares them in order.
module utf8_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       byte_present,
  input  logic       bad_hex,
  input  logic       out_last,
  output int         mismatches,
  output int         pending
);

  jued_pkg::phase_t scan_phase;
  logic [11:0]      digit_acc;
  logic             digit_bad;
  jued_pkg::res_t   utf8_expected[$];
  int               error_count = 0;

  // Decode one ASCII hex digit; the value is zero when the byte is not hex
  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic jued_pkg::res_t plain(input logic [7:0] b);
    jued_pkg::res_t r;
    r = '{data: b, present: 1'b1, bad: 1'b0, last: 1'b0};
    return r;
  endfunction

  task automatic clear_scan();
    scan_phase = jued_pkg::PH_IDLE;
    digit_acc  = 12'd0;
    digit_bad  = 1'b0;
  endtask

  // Advance the escape scanner by one text byte and queue what it gives
  task automatic decode_into_utf8(input logic [7:0] b, input logic final_byte);
    jued_pkg::res_t step_out[$];
    jued_pkg::res_t tail;
    logic [3:0]     nib;
    logic           is_hex;
    logic [15:0]    code;
    is_hex = hex_digit(b, nib);
    case (scan_phase)
      jued_pkg::PH_BSL: begin
        if (b == jued_pkg::CH_U) begin
          scan_phase = jued_pkg::PH_U;
          digit_acc  = 12'd0;
          digit_bad  = 1'b0;
        end else begin
          // a held backslash that opens no escape is copied; another
          // backslash stays held
          step_out.push_back(plain(jued_pkg::CH_BSL));
          if (b != jued_pkg::CH_BSL) begin
            step_out.push_back(plain(b));
            scan_phase = jued_pkg::PH_IDLE;
          end
        end
      end
      jued_pkg::PH_U, jued_pkg::PH_D1, jued_pkg::PH_D2: begin
        digit_acc = {digit_acc[7:0], nib};
        if (!is_hex) digit_bad = 1'b1;
        case (scan_phase)
          jued_pkg::PH_U:  scan_phase = jued_pkg::PH_D1;
          jued_pkg::PH_D1: scan_phase = jued_pkg::PH_D2;
          default:         scan_phase = jued_pkg::PH_D3;
        endcase
      end
      jued_pkg::PH_D3: begin
        code = {digit_acc, nib};
        if (!is_hex || digit_bad) begin
          tail     = plain(8'h00);
          tail.bad = 1'b1;
          step_out.push_back(tail);
        end else if (code < jued_pkg::LIM_ONE) begin
          step_out.push_back(plain(code[7:0]));
        end else if (code < jued_pkg::LIM_TWO) begin
          step_out.push_back(plain(jued_pkg::LEAD2 | {3'b000, code[10:6]}));
          step_out.push_back(plain(jued_pkg::CONT | {2'b00, code[5:0]}));
        end else begin
          step_out.push_back(plain(jued_pkg::LEAD3 | {4'b0000, code[15:12]}));
          step_out.push_back(plain(jued_pkg::CONT | {2'b00, code[11:6]}));
          step_out.push_back(plain(jued_pkg::CONT | {2'b00, code[5:0]}));
        end
        clear_scan();
      end
      default: begin
        scan_phase = jued_pkg::PH_IDLE;
        if (b == jued_pkg::CH_BSL) scan_phase = jued_pkg::PH_BSL;
        else step_out.push_back(plain(b));
      end
    endcase

    // Close the text: copy a held backslash, drop a cut-off escape, and
    // mark the final transaction
    if (final_byte) begin
      if (scan_phase == jued_pkg::PH_BSL) step_out.push_back(plain(jued_pkg::CH_BSL));
      if (step_out.size() == 0) begin
        tail         = plain(8'h00);
        tail.present = 1'b0;
        step_out.push_back(tail);
      end
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
      clear_scan();
    end
    foreach (step_out[i]) utf8_expected.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_output();
    jued_pkg::res_t want;
    if (utf8_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected output byte %02h present %b last %b",
                                out_byte, byte_present, out_last));
      return;
    end
    want = utf8_expected.pop_front();
    if (out_byte !== want.data)
      report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
    if (byte_present !== want.present)
      report_mismatch($sformatf("byte_present %b, want %b", byte_present, want.present));
    if (bad_hex !== want.bad)
      report_mismatch($sformatf("bad_hex %b, want %b", bad_hex, want.bad));
    if (out_last !== want.last)
      report_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      utf8_expected.delete();
    end else begin
      // outputs are registered and lag their inputs, so drain before predicting
      if (out_valid && !out_stall) check_output();
      if (in_valid && !in_stall) decode_into_utf8(in_byte, in_last);
    end
    pending    <= utf8_expected.size();
    mismatches <= error_count;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the JSON escape decoder: directed texts first,
// then random texts made mostly of well-formed escapes.
module tb;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_stall = 1'b0;
  logic       pacing_on = 1'b1;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       bad_hex;
  logic       out_last;
  int         mismatches;
  int         pending;
  int         stall_left = 0;
  int         items_sent = 0;
  logic [7:0] text_bytes[$];

  always #1 clk = ~clk;

  json_unicode_escape_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .bad_hex      (bad_hex),
    .out_last     (out_last)
  );

  utf8_stream_checker utf8_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .bad_hex      (bad_hex),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Stall the output side in random bursts
  always @(posedge clk) begin
    if (rst || !pacing_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  initial begin
    #200000;
    $display("FAIL json_unicode_escape_decoder_top");
    $finish;
  end

  // Offer one byte, maybe after an idle burst, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (pacing_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic flush_text();
    int k;
    for (k = 0; k < text_bytes.size(); k++) begin
      send_byte(text_bytes[k], k == text_bytes.size() - 1);
    end
    text_bytes.delete();
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    logic [7:0] base;
    if (n < 4'd10) return 8'h30 + n;
    base = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return base + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] v;
    do begin
      v = 8'($urandom_range(0, 255));
    end while ((v >= "0" && v <= "9") || (v >= "A" && v <= "F") ||
               (v >= "a" && v <= "f"));
    return v;
  endfunction

  // Append backslash, 'u' and four digits; spoil one digit when bad_pos is 0..3
  task automatic add_escape(input logic [15:0] code, input int bad_pos);
    int d;
    text_bytes.push_back(jued_pkg::CH_BSL);
    text_bytes.push_back(jued_pkg::CH_U);
    for (d = 0; d < 4; d++) begin
      if (d == bad_pos) text_bytes.push_back(non_hex_byte());
      else text_bytes.push_back(hex_ascii(code[15 - 4*d -: 4]));
    end
  endtask

  // Pick a code point, leaning on the one, two and three byte boundaries
  function automatic logic [15:0] pick_code();
    logic [15:0] corners[6];
    corners = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return corners[$urandom_range(0, 5)];
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Build one random text: mostly escapes, some noise, sometimes cut off
  task automatic build_random_text();
    int pieces;
    int cut;
    int d;
    logic [7:0] b;
    logic [15:0] code;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: text_bytes.push_back(8'($urandom_range(0, 255)));
        3, 4, 5, 6: add_escape(pick_code(), -1);
        7: add_escape(pick_code(), $urandom_range(0, 3));
        default: begin
          do b = 8'($urandom_range(0, 255)); while (b == jued_pkg::CH_U);
          text_bytes.push_back(jued_pkg::CH_BSL);
          text_bytes.push_back(b);
        end
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      cut  = $urandom_range(1, 5);
      code = pick_code();
      text_bytes.push_back(jued_pkg::CH_BSL);
      if (cut > 1) text_bytes.push_back(jued_pkg::CH_U);
      for (d = 0; d < cut - 2; d++) text_bytes.push_back(hex_ascii(code[15 - 4*d -: 4]));
    end
  endtask

  initial begin
    int goal;
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Held backslash ahead of an escape; 0xFFFF closes the text
    text_bytes.push_back(jued_pkg::CH_BSL);
    add_escape(16'hFFFF, -1);
    flush_text();
    // Byte extremes, backslash copy, escape cut off at the end marker
    text_bytes = '{8'h00, 8'hFF, jued_pkg::CH_BSL, "q", jued_pkg::CH_BSL, jued_pkg::CH_U,
                   "7", "g"};
    flush_text();
    // Bad digit, then a backslash as the final byte
    add_escape(16'h0001, 2);
    text_bytes.push_back(jued_pkg::CH_BSL);
    flush_text();
    // Top of the two byte range
    add_escape(16'h07FF, -1);
    flush_text();

    // Random texts; the last stretch runs without idling
    goal = items_sent + 200;
    while (items_sent < goal) begin
      if (goal - items_sent < 40) pacing_on <= 1'b0;
      else pacing_on <= ($urandom_range(0, 3) != 0);
      build_random_text();
      flush_text();
    end
    in_valid <= 1'b0;

    // Drain the outstanding transactions
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 4000);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS json_unicode_escape_decoder_top");
    end else begin
      $display("FAIL json_unicode_escape_decoder_top");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jued_pkg.sv
rtl/json_unicode_escape_decoder_top.sv
bench/utf8_stream_checker.sv
bench/tb.sv
